FILE: hw/rtl/go_to_goal_velocity_command_core_assert.svh
// Assertion macros shared by the go-to-goal controller RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GO_TO_GOAL_VELOCITY_COMMAND_CORE_ASSERT_SVH
`define GO_TO_GOAL_VELOCITY_COMMAND_CORE_ASSERT_SVH

// Property must hold on every clock edge outside reset
`define GGVC_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ggvc assertion failed");

// Same-cycle implication
`define GGVC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggvc assertion failed");

// Next-cycle implication
`define GGVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggvc assertion failed");

`endif

FILE: hw/rtl/ggvc_pkg.sv
// Shared constants, types and tables for the go-to-goal velocity command core.
// No dependencies; every RTL module refers to it by scoped names.
package ggvc_pkg;

   // Number of CORDIC micro-rotations (8 to 24)
   localparam int CORDIC_STEPS = 16;

   // Field widths
   localparam int POS_W      = 20;
   localparam int HEAD_W     = 16;
   localparam int DIFF_W     = POS_W + 1;
   localparam int XY_W       = DIFF_W + 2;
   localparam int Z_W        = 32;
   localparam int ANG_W      = 16;
   localparam int MAG_W      = ANG_W + 1;
   localparam int THR_W      = 15;
   localparam int GAIN_W     = 8;
   localparam int FWD_W      = 21;
   localparam int TURN_W     = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = THR_W;

   // Square root datapath
   localparam int PROD_W  = 2 * (DIFF_W - 1);
   localparam int SQ_W    = PROD_W + 1;
   localparam int ROOT_W  = (SQ_W + 1) / 2;
   localparam int TRIAL_W = SQ_W + 2;

   // Command multipliers
   localparam int TPROD_W    = GAIN_W + 1 + ANG_W;
   localparam int FPROD_W    = GAIN_W + ROOT_W;
   localparam int TURN_SHIFT = 4;
   localparam int TURN_ROUND = 8;
   localparam int FWD_ROUND  = 128;

   // Angle constants, pi = 2^31 in accumulator units
   localparam logic [Z_W-1:0] Z_QUARTER     = 32'h4000_0000;
   localparam logic [Z_W-1:0] Z_NEG_QUARTER = 32'hC000_0000;
   localparam logic [Z_W-1:0] Z_ROUND       = 32'h0000_8000;

   localparam logic [Z_W-1:0] ATAN_TAB [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // Pipeline latencies and alignment padding
   localparam int CORDIC_LAT = CORDIC_STEPS + 1;
   localparam int SQRT_LAT   = 2 + ROOT_W;
   localparam int UNIT_LAT   = (CORDIC_LAT > SQRT_LAT) ? CORDIC_LAT : SQRT_LAT;
   localparam int PAD_C      = UNIT_LAT - CORDIC_LAT;
   localparam int PAD_S      = UNIT_LAT - SQRT_LAT;

   // Queues
   localparam int MID_DEPTH = 4;
   localparam int MID_PTR_W = 2;
   localparam int MID_CNT_W = 3;
   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR_W = 1;
   localparam int OUT_CNT_W = 2;

   // Register reset values
   localparam logic [THR_W-1:0]  THRESHOLD_RESET   = 15'd1;
   localparam logic [GAIN_W-1:0] ANG_GAIN_RESET    = 8'd48;
   localparam logic [GAIN_W-1:0] LIN_GAIN_RESET    = 8'd205;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_THRESHOLD = 2'd0,
      CSR_ANGULAR_GAIN    = 2'd1,
      CSR_LINEAR_GAIN     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]  angle_threshold;
      logic [GAIN_W-1:0] angular_gain;
      logic [GAIN_W-1:0] linear_gain;
   } cfg_type;

   // Classified request held between front and back
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [HEAD_W-1:0] heading;
      logic                     zero;
   } mid_item_type;

   typedef struct packed {
      logic [FWD_W-1:0]         forward_speed;
      logic signed [TURN_W-1:0] turn_rate;
      logic                     turning;
   } rsp_item_type;

endpackage

FILE: hw/rtl/ggvc_front.sv
// Front end: accepts requests, forms goal offsets, flags the goal-on-robot case.
// Holds a four-entry queue toward the back end. Uses ggvc_pkg.
`include "go_to_goal_velocity_command_core_assert.svh"

module ggvc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [ggvc_pkg::POS_W-1:0]     req_robot_x,
   input  logic signed [ggvc_pkg::POS_W-1:0]     req_robot_y,
   input  logic signed [ggvc_pkg::HEAD_W-1:0]    req_robot_heading,
   input  logic signed [ggvc_pkg::POS_W-1:0]     req_goal_x,
   input  logic signed [ggvc_pkg::POS_W-1:0]     req_goal_y,
   output logic                                  mid_valid,
   output ggvc_pkg::mid_item_type                mid_item,
   input  logic                                  mid_take
);

   logic [ggvc_pkg::MID_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ggvc_pkg::MID_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ggvc_pkg::MID_CNT_W-1:0] mid_count_ff, mid_count_in;
   ggvc_pkg::mid_item_type         mid_mem_ff [ggvc_pkg::MID_DEPTH];
   ggvc_pkg::mid_item_type         new_item;
   logic                           wr_en;
   logic                           rd_en;

   assign req_full  = (mid_count_ff == ggvc_pkg::MID_CNT_W'(ggvc_pkg::MID_DEPTH));
   assign mid_valid = (mid_count_ff != '0);
   assign mid_item  = mid_mem_ff[rd_ptr_ff];
   assign wr_en     = req_push && !req_full;
   assign rd_en     = mid_take && mid_valid;

   // Offsets to the goal, one bit wider than the positions
   always_comb begin
      new_item.dx      = {req_goal_x[ggvc_pkg::POS_W-1], req_goal_x}
                       - {req_robot_x[ggvc_pkg::POS_W-1], req_robot_x};
      new_item.dy      = {req_goal_y[ggvc_pkg::POS_W-1], req_goal_y}
                       - {req_robot_y[ggvc_pkg::POS_W-1], req_robot_y};
      new_item.heading = req_robot_heading;
      new_item.zero    = (new_item.dx == '0) && (new_item.dy == '0);
   end

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in    = wr_en ? ggvc_pkg::MID_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in    = rd_en ? ggvc_pkg::MID_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      mid_count_in = mid_count_ff;
      if (wr_en && !rd_en) begin
         mid_count_in = ggvc_pkg::MID_CNT_W'(mid_count_ff + 1'b1);
      end else if (rd_en && !wr_en) begin
         mid_count_in = ggvc_pkg::MID_CNT_W'(mid_count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         mid_count_ff <= '0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         mid_count_ff <= mid_count_in;
      end
   end

   // Queue storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mid_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   `GGVC_ASSERT_ALWAYS(a_mid_count_bound, clock, reset,
      mid_count_ff <= ggvc_pkg::MID_CNT_W'(ggvc_pkg::MID_DEPTH))
   `GGVC_ASSERT_NEXT(a_full_blocks_write, clock, reset, req_full && !mid_take,
      mid_count_ff == ggvc_pkg::MID_CNT_W'(ggvc_pkg::MID_DEPTH))

endmodule

FILE: hw/rtl/ggvc_cordic.sv
// Vectoring CORDIC pipeline: one micro-rotation per stage, bearing of (dx, dy).
// Carries heading and the goal-on-robot flag alongside. Uses ggvc_pkg.
module ggvc_cordic (
   input  logic                               clock,
   input  logic                               en,
   input  ggvc_pkg::mid_item_type             in_item,
   output logic signed [ggvc_pkg::ANG_W-1:0]  bearing,
   output logic signed [ggvc_pkg::HEAD_W-1:0] heading
);

   localparam int N = ggvc_pkg::CORDIC_STEPS;

   logic signed [ggvc_pkg::XY_W-1:0]   x_ff  [N+1];
   logic signed [ggvc_pkg::XY_W-1:0]   y_ff  [N+1];
   logic        [ggvc_pkg::Z_W-1:0]    z_ff  [N+1];
   logic signed [ggvc_pkg::HEAD_W-1:0] hd_ff [N+1];
   logic                               zero_ff [N+1];

   logic signed [ggvc_pkg::XY_W-1:0] xs [N];
   logic signed [ggvc_pkg::XY_W-1:0] ys [N];
   logic signed [ggvc_pkg::XY_W-1:0] x_in [N];
   logic signed [ggvc_pkg::XY_W-1:0] y_in [N];
   logic        [ggvc_pkg::Z_W-1:0]  z_in [N];

   logic signed [ggvc_pkg::XY_W-1:0] dx_ext, dy_ext;
   logic signed [ggvc_pkg::XY_W-1:0] x0_in, y0_in;
   logic        [ggvc_pkg::Z_W-1:0]  z0_in;
   logic        [ggvc_pkg::Z_W-1:0]  z_round;

   assign dx_ext = {{(ggvc_pkg::XY_W-ggvc_pkg::DIFF_W){in_item.dx[ggvc_pkg::DIFF_W-1]}},
                    in_item.dx};
   assign dy_ext = {{(ggvc_pkg::XY_W-ggvc_pkg::DIFF_W){in_item.dy[ggvc_pkg::DIFF_W-1]}},
                    in_item.dy};

   // Left half plane: pre-rotate by a quarter turn toward the x axis
   always_comb begin
      x0_in = dx_ext;
      y0_in = dy_ext;
      z0_in = '0;
      if (dx_ext[ggvc_pkg::XY_W-1]) begin
         if (!dy_ext[ggvc_pkg::XY_W-1]) begin
            x0_in = dy_ext;
            y0_in = -dx_ext;
            z0_in = ggvc_pkg::Z_QUARTER;
         end else begin
            x0_in = -dy_ext;
            y0_in = dx_ext;
            z0_in = ggvc_pkg::Z_NEG_QUARTER;
         end
      end
   end

   // Micro-rotations: drive y toward zero, accumulate the angle
   for (genvar i = 0; i < N; i++) begin : g_step
      assign xs[i]   = x_ff[i] >>> i;
      assign ys[i]   = y_ff[i] >>> i;
      assign x_in[i] = y_ff[i][ggvc_pkg::XY_W-1] ? (x_ff[i] - ys[i]) : (x_ff[i] + ys[i]);
      assign y_in[i] = y_ff[i][ggvc_pkg::XY_W-1] ? (y_ff[i] + xs[i]) : (y_ff[i] - xs[i]);
      assign z_in[i] = y_ff[i][ggvc_pkg::XY_W-1] ? (z_ff[i] - ggvc_pkg::ATAN_TAB[i])
                                                 : (z_ff[i] + ggvc_pkg::ATAN_TAB[i]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         hd_ff[0]   <= in_item.heading;
         zero_ff[0] <= in_item.zero;
         for (int i = 0; i < N; i++) begin
            x_ff[i+1]    <= x_in[i];
            y_ff[i+1]    <= y_in[i];
            z_ff[i+1]    <= z_in[i];
            hd_ff[i+1]   <= hd_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // Round to 16-bit angle units; a zero vector has bearing zero
   assign z_round = z_ff[N] + ggvc_pkg::Z_ROUND;
   assign bearing = zero_ff[N] ? '0 : z_round[ggvc_pkg::Z_W-1 -: ggvc_pkg::ANG_W];
   assign heading = hd_ff[N];

endmodule

FILE: hw/rtl/ggvc_isqrt.sv
// Distance pipeline: squares the offsets, then a digit-by-digit square root,
// one result bit per stage. Uses ggvc_pkg.
module ggvc_isqrt (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [ggvc_pkg::DIFF_W-1:0]  dx,
   input  logic signed [ggvc_pkg::DIFF_W-1:0]  dy,
   output logic        [ggvc_pkg::ROOT_W-1:0]  distance
);

   localparam int R = ggvc_pkg::ROOT_W;

   logic signed [2*ggvc_pkg::DIFF_W-1:0] px, py;
   logic [ggvc_pkg::PROD_W-1:0]  sqx_ff, sqy_ff;
   logic [ggvc_pkg::SQ_W-1:0]    n_in;
   logic [ggvc_pkg::SQ_W-1:0]    rem_ff  [R+1];
   logic [R-1:0]                 root_ff [R+1];
   logic [ggvc_pkg::TRIAL_W-1:0] trial   [R];
   logic                         fit     [R];
   logic [ggvc_pkg::SQ_W-1:0]    rem_in  [R];
   logic [R-1:0]                 root_in [R];

   // Squares and their sum
   assign px   = dx * dx;
   assign py   = dy * dy;
   assign n_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // Root bit b: accept it if (root + 2^b)^2 still fits under the operand
   for (genvar k = 0; k < R; k++) begin : g_digit
      localparam int B = R - 1 - k;
      assign trial[k]   = (ggvc_pkg::TRIAL_W'(root_ff[k]) << (B + 1))
                        | (ggvc_pkg::TRIAL_W'(1) << (2 * B));
      assign fit[k]     = ggvc_pkg::TRIAL_W'(rem_ff[k]) >= trial[k];
      assign rem_in[k]  = fit[k]
                        ? ggvc_pkg::SQ_W'(ggvc_pkg::TRIAL_W'(rem_ff[k]) - trial[k])
                        : rem_ff[k];
      assign root_in[k] = fit[k] ? (root_ff[k] | (R'(1) << B)) : root_ff[k];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff     <= px[ggvc_pkg::PROD_W-1:0];
         sqy_ff     <= py[ggvc_pkg::PROD_W-1:0];
         rem_ff[0]  <= n_in;
         root_ff[0] <= '0;
         for (int k = 0; k < R; k++) begin
            rem_ff[k+1]  <= rem_in[k];
            root_ff[k+1] <= root_in[k];
         end
      end
   end

   assign distance = root_ff[R];

endmodule

FILE: hw/rtl/ggvc_back.sv
// Back end: bearing and distance units, bearing error and command stages,
// and a two-entry result queue. Uses ggvc_pkg, ggvc_cordic and ggvc_isqrt.
`include "go_to_goal_velocity_command_core_assert.svh"

module ggvc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ggvc_pkg::cfg_type       cfg,
   input  logic                    mid_valid,
   input  ggvc_pkg::mid_item_type  mid_item,
   output logic                    mid_take,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output ggvc_pkg::rsp_item_type  rsp_item
);

   logic                                en;
   logic [ggvc_pkg::UNIT_LAT-1:0]       vld_ff;
   logic signed [ggvc_pkg::ANG_W-1:0]   c_bearing, a_bearing;
   logic signed [ggvc_pkg::HEAD_W-1:0]  c_heading, a_heading;
   logic [ggvc_pkg::ROOT_W-1:0]         s_dist, a_dist;

   // Error stage
   logic signed [ggvc_pkg::ANG_W-1:0]   err_in, err_ff;
   logic [ggvc_pkg::MAG_W-1:0]          mag;
   logic                                turning_in, turning_ff;
   logic [ggvc_pkg::ROOT_W-1:0]         dist_ff;
   logic                                vld_e_ff;

   // Command stage
   logic signed [ggvc_pkg::TPROD_W-1:0] tsum;
   logic [ggvc_pkg::FPROD_W-1:0]        fsum;
   ggvc_pkg::rsp_item_type              out_in, out_ff;
   logic                                vld_m_ff;

   // Result queue
   ggvc_pkg::rsp_item_type              out_mem_ff [ggvc_pkg::OUT_DEPTH];
   logic [ggvc_pkg::OUT_PTR_W-1:0]      out_wr_ff, out_wr_in, out_rd_ff, out_rd_in;
   logic [ggvc_pkg::OUT_CNT_W-1:0]      out_count_ff, out_count_in;
   logic                                push, pop;

   // Whole pipeline advances while the result queue has room
   assign en       = (out_count_ff != ggvc_pkg::OUT_CNT_W'(ggvc_pkg::OUT_DEPTH));
   assign mid_take = en && mid_valid;

   ggvc_cordic u_cordic (
      .clock   (clock),
      .en      (en),
      .in_item (mid_item),
      .bearing (c_bearing),
      .heading (c_heading)
   );

   ggvc_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .dx       (mid_item.dx),
      .dy       (mid_item.dy),
      .distance (s_dist)
   );

   // Pad the shorter unit so both results line up
   if (ggvc_pkg::PAD_C > 0) begin : g_pad_c
      logic signed [ggvc_pkg::ANG_W-1:0]  pb_ff [ggvc_pkg::PAD_C];
      logic signed [ggvc_pkg::HEAD_W-1:0] ph_ff [ggvc_pkg::PAD_C];
      always_ff @(posedge clock) begin
         if (en) begin
            pb_ff[0] <= c_bearing;
            ph_ff[0] <= c_heading;
            for (int j = 1; j < ggvc_pkg::PAD_C; j++) begin
               pb_ff[j] <= pb_ff[j-1];
               ph_ff[j] <= ph_ff[j-1];
            end
         end
      end
      assign a_bearing = pb_ff[ggvc_pkg::PAD_C-1];
      assign a_heading = ph_ff[ggvc_pkg::PAD_C-1];
   end else begin : g_no_pad_c
      assign a_bearing = c_bearing;
      assign a_heading = c_heading;
   end

   if (ggvc_pkg::PAD_S > 0) begin : g_pad_s
      logic [ggvc_pkg::ROOT_W-1:0] pd_ff [ggvc_pkg::PAD_S];
      always_ff @(posedge clock) begin
         if (en) begin
            pd_ff[0] <= s_dist;
            for (int j = 1; j < ggvc_pkg::PAD_S; j++) begin
               pd_ff[j] <= pd_ff[j-1];
            end
         end
      end
      assign a_dist = pd_ff[ggvc_pkg::PAD_S-1];
   end else begin : g_no_pad_s
      assign a_dist = s_dist;
   end

   // Bearing error wraps to 16 bits; its magnitude picks turn or drive
   always_comb begin
      err_in     = a_bearing - a_heading;
      mag        = err_in[ggvc_pkg::ANG_W-1] ? (ggvc_pkg::MAG_W'(0) - {1'b1, err_in})
                                             : {1'b0, err_in};
      turning_in = mag > {2'b00, cfg.angle_threshold};
   end

   // Gains with rounding; both results stay inside their field ranges
   assign tsum = ($signed({1'b0, cfg.angular_gain}) * err_ff)
               + ggvc_pkg::TPROD_W'(ggvc_pkg::TURN_ROUND);
   assign fsum = (cfg.linear_gain * dist_ff) + ggvc_pkg::FPROD_W'(ggvc_pkg::FWD_ROUND);

   always_comb begin
      out_in.turning = turning_ff;
      if (turning_ff) begin
         out_in.forward_speed = '0;
         out_in.turn_rate     = tsum[ggvc_pkg::TURN_SHIFT +: ggvc_pkg::TURN_W];
      end else begin
         out_in.forward_speed = fsum[ggvc_pkg::FPROD_W-1 -: ggvc_pkg::FWD_W];
         out_in.turn_rate     = '0;
      end
   end

   // Valid bits for unit, error and command stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_e_ff <= 1'b0;
         vld_m_ff <= 1'b0;
      end else if (en) begin
         vld_ff   <= {vld_ff[ggvc_pkg::UNIT_LAT-2:0], mid_valid};
         vld_e_ff <= vld_ff[ggvc_pkg::UNIT_LAT-1];
         vld_m_ff <= vld_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_ff     <= err_in;
         turning_ff <= turning_in;
         dist_ff    <= a_dist;
         out_ff     <= out_in;
      end
   end

   // Result queue control
   assign push      = en && vld_m_ff;
   assign rsp_empty = (out_count_ff == '0);
   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_item  = out_mem_ff[out_rd_ff];

   always_comb begin
      out_wr_in    = push ? ggvc_pkg::OUT_PTR_W'(out_wr_ff + 1'b1) : out_wr_ff;
      out_rd_in    = pop  ? ggvc_pkg::OUT_PTR_W'(out_rd_ff + 1'b1) : out_rd_ff;
      out_count_in = out_count_ff;
      if (push && !pop) begin
         out_count_in = ggvc_pkg::OUT_CNT_W'(out_count_ff + 1'b1);
      end else if (pop && !push) begin
         out_count_in = ggvc_pkg::OUT_CNT_W'(out_count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_mem_ff[out_wr_ff] <= out_ff;
      end
   end

   `GGVC_ASSERT_IMPL(a_turn_no_speed, clock, reset, !rsp_empty && rsp_item.turning,
      rsp_item.forward_speed == '0)
   `GGVC_ASSERT_IMPL(a_drive_no_turn, clock, reset, !rsp_empty && !rsp_item.turning,
      rsp_item.turn_rate == '0)
   `GGVC_ASSERT_NEXT(a_freeze_holds, clock, reset, !en, $stable(vld_ff))

endmodule

FILE: hw/rtl/go_to_goal_velocity_command_core.sv
// Go-to-goal velocity command core: robot pose and goal in, one velocity command out.
// Request side is a queue input: hold the pose on req_* and raise req_push; it is
// taken at each rising edge with req_full low. Commands come out as a queue: while
// rsp_empty is low the oldest command is on rsp_*; rsp_pop takes it.
// Registers are written through csr_write_en / csr_index / csr_write_data; the user must
// write them only while idle, and the block does not enforce this. Index 0 is the angle
// threshold, 1 angular gain, 2 linear gain; other indexes are ignored. Throughput is one
// request per cycle while req_full is low. The shorter of the square root pipeline
// (squares, sum, 21 digit stages) and the CORDIC pipeline is padded to line them up.
// When rsp_pop is held low the two-entry result queue fills, the back-end pipeline
// freezes in place, the four-entry front queue absorbs further requests and then
// req_full rises. Nothing is dropped. Synchronous reset empties both queues, clears
// all pipeline valids and loads the register defaults (threshold 1, gains 48 and 205).
// Depends on ggvc_pkg, ggvc_front and ggvc_back.
module go_to_goal_velocity_command_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic signed [ggvc_pkg::POS_W-1:0]       req_robot_x,
   input  logic signed [ggvc_pkg::POS_W-1:0]       req_robot_y,
   input  logic signed [ggvc_pkg::HEAD_W-1:0]      req_robot_heading,
   input  logic signed [ggvc_pkg::POS_W-1:0]       req_goal_x,
   input  logic signed [ggvc_pkg::POS_W-1:0]       req_goal_y,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic        [ggvc_pkg::FWD_W-1:0]       rsp_forward_speed,
   output logic signed [ggvc_pkg::TURN_W-1:0]      rsp_turn_rate,
   output logic                                    rsp_turning,
   input  logic                                    csr_write_en,
   input  logic        [ggvc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [ggvc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   ggvc_pkg::cfg_type      cfg_ff, cfg_in;
   logic                   mid_valid;
   logic                   mid_take;
   ggvc_pkg::mid_item_type mid_item;
   ggvc_pkg::rsp_item_type rsp_item;

   // Control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (ggvc_pkg::csr_index_type'(csr_index))
            ggvc_pkg::CSR_ANGLE_THRESHOLD: begin
               cfg_in.angle_threshold = csr_write_data;
            end
            ggvc_pkg::CSR_ANGULAR_GAIN: begin
               cfg_in.angular_gain = csr_write_data[ggvc_pkg::GAIN_W-1:0];
            end
            ggvc_pkg::CSR_LINEAR_GAIN: begin
               cfg_in.linear_gain = csr_write_data[ggvc_pkg::GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_threshold <= ggvc_pkg::THRESHOLD_RESET;
         cfg_ff.angular_gain    <= ggvc_pkg::ANG_GAIN_RESET;
         cfg_ff.linear_gain     <= ggvc_pkg::LIN_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ggvc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_robot_x       (req_robot_x),
      .req_robot_y       (req_robot_y),
      .req_robot_heading (req_robot_heading),
      .req_goal_x        (req_goal_x),
      .req_goal_y        (req_goal_y),
      .mid_valid         (mid_valid),
      .mid_item          (mid_item),
      .mid_take          (mid_take)
   );

   ggvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_valid (mid_valid),
      .mid_item  (mid_item),
      .mid_take  (mid_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_forward_speed = rsp_item.forward_speed;
   assign rsp_turn_rate     = rsp_item.turn_rate;
   assign rsp_turning       = rsp_item.turning;

endmodule

FILE: tb/sv/tb_go_to_goal_velocity_command_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for go_to_goal_velocity_command_core: directed table, random poses.
// A local CORDIC/isqrt predictor checks untyped commands under several register settings.
// Depends on ggvc_pkg and go_to_goal_velocity_command_core.
module tb_go_to_goal_velocity_command_core;

   // Register index with no register behind it; writes to it are dropped
   localparam logic [ggvc_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // Register values after reset
   localparam logic [ggvc_pkg::THR_W-1:0]  DEF_THRESHOLD = 15'd1;
   localparam logic [ggvc_pkg::GAIN_W-1:0] DEF_ANG_GAIN  = 8'd48;
   localparam logic [ggvc_pkg::GAIN_W-1:0] DEF_LIN_GAIN  = 8'd205;

   // Arctangent table, pi = 2^31
   localparam longint ARC_TAN [0:23] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
      64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
   };

   localparam int RANDOM_PHASES    = 6;
   localparam int ITEMS_PER_PHASE  = 150;
   localparam int TAIL_CYCLES      = 40;
   localparam int MAX_PRINTED      = 50;

   typedef struct packed {
      logic signed [ggvc_pkg::POS_W-1:0]  robot_x;
      logic signed [ggvc_pkg::POS_W-1:0]  robot_y;
      logic signed [ggvc_pkg::HEAD_W-1:0] robot_heading;
      logic signed [ggvc_pkg::POS_W-1:0]  goal_x;
      logic signed [ggvc_pkg::POS_W-1:0]  goal_y;
   } pose_type;

   // Typed-in expectation; typed = 0 means use the predictor
   typedef struct packed {
      logic                   typed;
      ggvc_pkg::rsp_item_type want;
   } golden_type;

   typedef struct packed {
      pose_type   pose;
      golden_type golden;
   } stim_row_type;

   // DUT inputs, known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic signed [ggvc_pkg::POS_W-1:0]  req_robot_x = '0;
   logic signed [ggvc_pkg::POS_W-1:0]  req_robot_y = '0;
   logic signed [ggvc_pkg::HEAD_W-1:0] req_robot_heading = '0;
   logic signed [ggvc_pkg::POS_W-1:0]  req_goal_x = '0;
   logic signed [ggvc_pkg::POS_W-1:0]  req_goal_y = '0;
   logic rsp_pop = 1'b0;
   logic csr_write_en = 1'b0;
   logic [ggvc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ggvc_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   // DUT outputs
   logic                               req_full;
   logic                               rsp_empty;
   logic [ggvc_pkg::FWD_W-1:0]         rsp_forward_speed;
   logic signed [ggvc_pkg::TURN_W-1:0] rsp_turn_rate;
   logic                               rsp_turning;

   // Checker state
   ggvc_pkg::cfg_type      reg_shadow;
   ggvc_pkg::rsp_item_type pending_commands[$];
   golden_type             typed_commands[$];
   stim_row_type           directed_rows[$];
   int                     error_count = 0;
   bit                     send_idle_on = 1'b1;
   bit                     pop_idle_on = 1'b1;
   int                     pop_hold = 0;

   go_to_goal_velocity_command_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_robot_x       (req_robot_x),
      .req_robot_y       (req_robot_y),
      .req_robot_heading (req_robot_heading),
      .req_goal_x        (req_goal_x),
      .req_goal_y        (req_goal_y),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_forward_speed (rsp_forward_speed),
      .rsp_turn_rate     (rsp_turn_rate),
      .rsp_turning       (rsp_turning),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // Vectoring CORDIC; bearing in 16-bit angle units, not yet wrapped
   function automatic longint cordic_bearing(input longint dx, input longint dy);
      longint x, y, z, xs, ys, t;
      int     i;
      if (dx == 0 && dy == 0) return 0;
      x = dx;
      y = dy;
      z = 0;
      // Left half plane: pre-rotate by a quarter turn
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = longint'(1) <<< 30;
         end else begin
            x = -y;
            y = t;
            z = -(longint'(1) <<< 30);
         end
      end
      for (i = 0; i < ggvc_pkg::CORDIC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARC_TAN[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARC_TAN[i];
         end
      end
      return (z + 32768) >>> 16;
   endfunction

   // Floor square root, digit by digit
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, probe;
      root  = 0;
      probe = longint'(1) << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n    = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic ggvc_pkg::rsp_item_type predict_command(input pose_type p);
      longint                 dx, dy, brg, err, mag, tr;
      longint unsigned        distance, fs;
      logic [15:0]            err16;
      ggvc_pkg::rsp_item_type r;
      dx    = longint'($signed(p.goal_x)) - longint'($signed(p.robot_x));
      dy    = longint'($signed(p.goal_y)) - longint'($signed(p.robot_y));
      brg   = cordic_bearing(dx, dy);
      err16 = 16'(brg - longint'($signed(p.robot_heading)));
      err   = longint'($signed(err16));
      mag   = (err < 0) ? -err : err;
      if (mag > longint'(reg_shadow.angle_threshold)) begin
         // Turn in place
         tr = (longint'(reg_shadow.angular_gain) * err + 8) >>> 4;
         if (tr > 524287) tr = 524287;
         if (tr < -524288) tr = -524288;
         r.forward_speed = '0;
         r.turn_rate     = tr[ggvc_pkg::TURN_W-1:0];
         r.turning       = 1'b1;
      end else begin
         // Drive toward the goal
         distance = int_sqrt(longint'(dx * dx + dy * dy));
         fs       = (longint'(reg_shadow.linear_gain) * distance + 128) >> 8;
         if (fs > 64'h1FFFFF) fs = 64'h1FFFFF;
         r.forward_speed = fs[ggvc_pkg::FWD_W-1:0];
         r.turn_rate     = '0;
         r.turning       = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Monitor and scoreboard
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      pose_type               seen;
      golden_type             golden;
      ggvc_pkg::rsp_item_type exp_cmd;
      if (reset) begin
         reg_shadow.angle_threshold = DEF_THRESHOLD;
         reg_shadow.angular_gain    = DEF_ANG_GAIN;
         reg_shadow.linear_gain     = DEF_LIN_GAIN;
      end else begin
         // Register writes, masked to register width
         if (csr_write_en) begin
            case (csr_index)
               ggvc_pkg::CSR_ANGLE_THRESHOLD:
                  reg_shadow.angle_threshold = csr_write_data[ggvc_pkg::THR_W-1:0];
               ggvc_pkg::CSR_ANGULAR_GAIN:
                  reg_shadow.angular_gain    = csr_write_data[ggvc_pkg::GAIN_W-1:0];
               ggvc_pkg::CSR_LINEAR_GAIN:
                  reg_shadow.linear_gain     = csr_write_data[ggvc_pkg::GAIN_W-1:0];
               default: ;
            endcase
         end
         // Accepted request: queue its expected command
         if (req_push && !req_full) begin
            seen.robot_x       = req_robot_x;
            seen.robot_y       = req_robot_y;
            seen.robot_heading = req_robot_heading;
            seen.goal_x        = req_goal_x;
            seen.goal_y        = req_goal_y;
            golden.typed       = 1'b0;
            golden.want        = '0;
            if (typed_commands.size() != 0) golden = typed_commands.pop_front();
            exp_cmd = golden.typed ? golden.want : predict_command(seen);
            pending_commands.push_back(exp_cmd);
         end
         // Accepted command: compare with the oldest expectation
         if (rsp_pop && !rsp_empty) begin
            if (pending_commands.size() == 0) begin
               report_mismatch("command with no request outstanding");
            end else begin
               exp_cmd = pending_commands.pop_front();
               if (rsp_forward_speed !== exp_cmd.forward_speed)
                  report_mismatch($sformatf("forward_speed: expected %0d, got %0d",
                                            exp_cmd.forward_speed, rsp_forward_speed));
               if (rsp_turn_rate !== exp_cmd.turn_rate)
                  report_mismatch($sformatf("turn_rate: expected %0d, got %0d",
                                            $signed(exp_cmd.turn_rate), rsp_turn_rate));
               if (rsp_turning !== exp_cmd.turning)
                  report_mismatch($sformatf("turning: expected %0b, got %0b",
                                            exp_cmd.turning, rsp_turning));
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Result side: random stalls while enabled
   always @(posedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if (pop_idle_on && $urandom_range(0, 99) < 20) begin
         rsp_pop  <= 1'b0;
         pop_hold <= gap_length() - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   function automatic logic signed [ggvc_pkg::POS_W-1:0] edge_coord();
      case ($urandom_range(0, 5))
         0:       return 20'h80000;
         1:       return 20'h7FFFF;
         2:       return 20'h00000;
         3:       return 20'hFFFFF;
         4:       return 20'h00001;
         default: return 20'h80001;
      endcase
   endfunction

   // Random pose; most headings aimed near the true bearing so both modes occur
   function automatic pose_type make_random_pose(input int thr);
      pose_type p;
      int       kind, off;
      longint   dx, dy, brg;
      kind      = $urandom_range(0, 9);
      p.robot_x = 20'($urandom);
      p.robot_y = 20'($urandom);
      if (kind <= 3) begin
         p.goal_x = 20'($urandom);
         p.goal_y = 20'($urandom);
      end else if (kind <= 6) begin
         p.goal_x = p.robot_x + 20'(int'($urandom_range(0, 8191)) - 4096);
         p.goal_y = p.robot_y + 20'(int'($urandom_range(0, 8191)) - 4096);
      end else begin
         p.robot_x = edge_coord();
         p.robot_y = edge_coord();
         p.goal_x  = edge_coord();
         p.goal_y  = edge_coord();
      end
      if ($urandom_range(0, 9) < 6) begin
         dx  = longint'($signed(p.goal_x)) - longint'($signed(p.robot_x));
         dy  = longint'($signed(p.goal_y)) - longint'($signed(p.robot_y));
         brg = cordic_bearing(dx, dy);
         off = int'($urandom_range(0, 2 * thr + 2)) - (thr + 1);
         p.robot_heading = 16'(brg - longint'(off));
      end else begin
         p.robot_heading = 16'($urandom);
      end
      return p;
   endfunction

   task automatic add_row(input int rx, input int ry, input int hd, input int gx,
                          input int gy, input bit typed = 1'b0, input int fs = 0,
                          input int tr = 0, input bit trn = 1'b0);
      stim_row_type row;
      row.pose.robot_x                 = 20'(rx);
      row.pose.robot_y                 = 20'(ry);
      row.pose.robot_heading           = 16'(hd);
      row.pose.goal_x                  = 20'(gx);
      row.pose.goal_y                  = 20'(gy);
      row.golden.typed                 = typed;
      row.golden.want.forward_speed    = 21'(fs);
      row.golden.want.turn_rate        = 20'(tr);
      row.golden.want.turning          = trn;
      directed_rows.push_back(row);
   endtask

   // One request: hold it until accepted, then maybe idle
   task automatic send_pose(input pose_type p);
      req_robot_x       <= p.robot_x;
      req_robot_y       <= p.robot_y;
      req_robot_heading <= p.robot_heading;
      req_goal_x        <= p.goal_x;
      req_goal_y        <= p.goal_y;
      req_push          <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (send_idle_on && $urandom_range(0, 99) < 25) begin
         req_push <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   // Hold off requests until every command has come back
   task automatic drain_commands();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_commands.size() != 0) @(posedge clock);
   endtask

   // Caller lowers csr_write_en after the last write of a batch
   task automatic write_csr(input logic [ggvc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ggvc_pkg::CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int i, phase, thr_now;

      // Directed table under reset settings (threshold 1, gains 48 and 205)
      // Goal on robot: bearing 0, error is minus the heading
      add_row(0, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0);
      add_row(123, -456, -32768, 123, -456, 1'b1, 0, -98304, 1'b1);   // error of -pi
      add_row(123, -456, 16384, 123, -456, 1'b1, 0, -49152, 1'b1);
      add_row(-7, 9, -16384, -7, 9, 1'b1, 0, 49152, 1'b1);
      add_row(-524288, 524287, 32767, -524288, 524287, 1'b1, 0, -98301, 1'b1);
      add_row(5, 5, 1, 5, 5, 1'b1, 0, 0, 1'b0);                    // at threshold: drive
      add_row(5, 5, -1, 5, 5, 1'b1, 0, 0, 1'b0);
      add_row(5, 5, 2, 5, 5, 1'b1, 0, -6, 1'b1);                   // just above threshold
      // Extreme offsets and every quadrant
      add_row(-524288, -524288, 8192, 524287, 524287);
      add_row(524287, 524287, -24576, -524288, -524288);
      add_row(524287, -524288, 24576, -524288, 524287);
      add_row(-524288, 524287, -8192, 524287, -524288);
      add_row(0, 0, 0, 524287, 0);
      add_row(0, 0, -32768, -524288, 0);
      add_row(0, 0, 16384, 0, 524287);
      add_row(0, 0, -16384, 0, -524288);
      add_row(0, 0, -20000, -1000, -1);
      add_row(0, 0, 0, -1, 0);
      add_row(0, 0, 8192, 1, 1);
      add_row(100, 200, 16384, 100, 201);
      add_row(-1, -1, 8193, 0, 0);
      add_row(1000, -3000, 32767, 4096, 4096);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         typed_commands.push_back(directed_rows[i].golden);
         send_pose(directed_rows[i].pose);
      end

      // Random phases, each under its own register setting
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_commands();
         case (phase)
            0: begin
               thr_now = 0;
               write_csr(ggvc_pkg::CSR_ANGLE_THRESHOLD, 15'd0);
               write_csr(ggvc_pkg::CSR_ANGULAR_GAIN, 15'h00FF);
               write_csr(ggvc_pkg::CSR_LINEAR_GAIN, 15'h7FFF);     // upper bits dropped
               send_idle_on = 1'b1;
               pop_idle_on  = 1'b1;
            end
            1: begin
               thr_now = 32767;
               write_csr(ggvc_pkg::CSR_ANGLE_THRESHOLD, 15'h7FFF);
               write_csr(ggvc_pkg::CSR_ANGULAR_GAIN, 15'd0);
               write_csr(ggvc_pkg::CSR_LINEAR_GAIN, 15'h7F00);     // masks to zero
               send_idle_on = 1'b0;
               pop_idle_on  = 1'b0;
            end
            2: begin
               thr_now = $urandom_range(0, 32767);
               write_csr(ggvc_pkg::CSR_ANGLE_THRESHOLD, 15'(thr_now));
               write_csr(ggvc_pkg::CSR_ANGULAR_GAIN, 15'($urandom));
               write_csr(ggvc_pkg::CSR_LINEAR_GAIN, 15'($urandom));
               write_csr(CSR_UNUSED_INDEX, 15'($urandom));
               send_idle_on = 1'b1;
               pop_idle_on  = 1'b0;
            end
            3: begin
               thr_now = $urandom_range(0, 64);
               write_csr(ggvc_pkg::CSR_ANGLE_THRESHOLD, 15'(thr_now));
               write_csr(ggvc_pkg::CSR_ANGULAR_GAIN, 15'd1);
               write_csr(ggvc_pkg::CSR_LINEAR_GAIN, 15'd1);
               send_idle_on = 1'b0;
               pop_idle_on  = 1'b1;
            end
            4: begin
               thr_now = $urandom_range(0, 32767);
               write_csr(ggvc_pkg::CSR_ANGLE_THRESHOLD, 15'(thr_now));
               write_csr(ggvc_pkg::CSR_ANGULAR_GAIN, 15'($urandom_range(0, 255)));
               write_csr(ggvc_pkg::CSR_LINEAR_GAIN, 15'($urandom_range(0, 255)));
               send_idle_on = 1'b1;
               pop_idle_on  = 1'b1;
            end
            default: begin
               // Back to reset values; unused index must not disturb them
               thr_now = 1;
               write_csr(ggvc_pkg::CSR_ANGLE_THRESHOLD, 15'd1);
               write_csr(ggvc_pkg::CSR_ANGULAR_GAIN, 15'd48);
               write_csr(ggvc_pkg::CSR_LINEAR_GAIN, 15'd205);
               write_csr(CSR_UNUSED_INDEX, 15'h7FFF);
               send_idle_on = 1'b1;
               pop_idle_on  = 1'b1;
            end
         endcase
         csr_write_en <= 1'b0;
         repeat (ITEMS_PER_PHASE) send_pose(make_random_pose(thr_now));
      end

      // Wind down: all commands back, then a quiet tail for strays
      drain_commands();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_commands.size() != 0)
         report_mismatch($sformatf("%0d commands never arrived", pending_commands.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
